// ----- hw/rtl/flow_admission_shortest_path_macros.svh -----
// Assertion macros for the flow admission router RTL, used by fap_dp.
// Expects clk and rst_n in the scope of each use.
`ifndef FLOW_ADMISSION_SHORTEST_PATH_MACROS_SVH
`define FLOW_ADMISSION_SHORTEST_PATH_MACROS_SVH

// same-cycle implication, held off during reset
`define FAP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define FAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fap_pkg.sv -----
// Shared types and constants of the flow admission router.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fap_pkg;

  localparam int NODES       = 32;
  localparam int NW          = 5;
  localparam int NCW         = 6;
  localparam int LINKS       = 64;
  localparam int LW          = 6;
  localparam int ADJ_W       = 7;
  localparam int ADJ_DEPTH   = NODES * NODES;
  localparam int ADJ_AW      = 10;
  localparam int AMT_W       = 16;
  localparam int TAG_W       = 16;
  localparam int DIST_W      = 40;
  localparam int COST_W      = 33;
  localparam int QUO_W       = 32;
  localparam int TOTAL_W     = 32;
  localparam int COUNT_W     = 16;
  localparam int MAX_RES     = 32;
  localparam int LEN_W       = 6;
  localparam int KW          = 5;
  localparam int LINK_WORD_W = AMT_W + AMT_W + COST_W;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 72;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {{(DIST_W-1){1'b1}}, 1'b0};
  localparam logic [COST_W-1:0] COST_UNUSABLE = {1'b1, {QUO_W{1'b0}}};

  typedef enum logic [2:0] {
    ST_STORED         = 3'd0,
    ST_ACCEPTED       = 3'd1,
    ST_OVER_CAP       = 3'd2,
    ST_UNREACHABLE    = 3'd3,
    ST_QUEUE_OVERFLOW = 3'd4
  } fap_status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_STORE_AB, S_STORE_BA, S_ROUTE_INIT, S_POP, S_POP_WAIT,
    S_SCAN, S_SCAN_ADJ, S_SCAN_COST, S_PATH_WALK, S_CHK_ADJ, S_CHK_LINK,
    S_CHK_CMP, S_UPD_ADJ, S_UPD_LINK, S_UPD_CALC, S_UPD_DIV, S_UPD_WRITE,
    S_TOTALS, S_EMIT_PATH, S_FINAL
  } fap_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR_STEP, OP_CAPTURE, OP_STORE_AB, OP_STORE_BA,
    OP_ROUTE_INIT, OP_POP_LATCH, OP_NEXT_VISIT, OP_SCAN_READ, OP_SCAN_SKIP,
    OP_RELAX, OP_WALK_INIT, OP_WALK, OP_WALK_SRC, OP_WALK_STEP,
    OP_WALK_RESTART, OP_UPD_CALC, OP_UPD_WRITE, OP_TOTALS, OP_EMIT_PATH,
    OP_EMIT_FINAL
  } fap_op_t;

  typedef struct packed {
    fap_op_t     op;
    fap_status_t code;
  } fap_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ends_bad;
    logic queue_empty;
    logic dst_unreached;
    logic scan_done;
    logic adj_absent;
    logic skip_link;
    logic queue_full;
    logic walk_at_src;
    logic walk_too_long;
    logic over_cap;
    logic cap_full;
    logic div_busy;
    logic out_free;
    logic emit_last;
  } fap_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fap_div.sv -----
// Restoring divider, one quotient bit per cycle, for the Q16.16 link cost.
// Depends on fap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fap_div import fap_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [QUO_W-1:0] dividend,
  input  wire logic [AMT_W-1:0] divisor,
  output logic                  busy,
  output logic      [QUO_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [AMT_W-1:0] rem_r, rem_nxt;
  logic [AMT_W-1:0] dvs_r, dvs_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [AMT_W:0]   trial;
  logic             take;

  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(QUO_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = take ? AMT_W'(trial - {1'b0, dvs_r}) : trial[AMT_W-1:0];
      quo_nxt  = {quo_r[QUO_W-2:0], take};
      cnt_nxt  = cnt_r - 6'd1;
      busy_nxt = cnt_r != 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fap_ctrl.sv -----
// Controller state machine: sequences link stores, the queue search, path walk, path checks, load updates and output.
// Depends on fap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fap_ctrl import fap_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_tuser,
  output logic           in_tready,
  input  wire fap_stat_t stat,
  output fap_cmd_t       cmd
);

  fap_state_t  state_r, state_nxt;
  fap_status_t code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      S_CLEAR:      if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:       if (in_tvalid) state_nxt = in_tuser ? S_ROUTE_INIT : S_STORE_AB;
      S_STORE_AB:   state_nxt = S_STORE_BA;
      S_STORE_BA: begin
        code_nxt  = ST_STORED;
        state_nxt = S_FINAL;
      end
      S_ROUTE_INIT: begin
        if (stat.ends_bad) begin
          code_nxt  = ST_UNREACHABLE;
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (!stat.queue_empty) begin
          state_nxt = S_POP_WAIT;
        end else if (stat.dst_unreached) begin
          code_nxt  = ST_UNREACHABLE;
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_PATH_WALK;
        end
      end
      S_POP_WAIT:   state_nxt = S_SCAN;
      S_SCAN:       state_nxt = stat.scan_done ? S_POP : S_SCAN_ADJ;
      S_SCAN_ADJ:   state_nxt = stat.adj_absent ? S_SCAN : S_SCAN_COST;
      S_SCAN_COST: begin
        if (!stat.skip_link && stat.queue_full) begin
          code_nxt  = ST_QUEUE_OVERFLOW;
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_PATH_WALK: begin
        if (stat.walk_at_src) begin
          state_nxt = S_CHK_ADJ;
        end else if (stat.walk_too_long) begin
          code_nxt  = ST_UNREACHABLE;
          state_nxt = S_FINAL;
        end
      end
      S_CHK_ADJ:    state_nxt = stat.walk_at_src ? S_UPD_ADJ : S_CHK_LINK;
      S_CHK_LINK:   state_nxt = S_CHK_CMP;
      S_CHK_CMP: begin
        if (stat.over_cap) begin
          code_nxt  = ST_OVER_CAP;
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_CHK_ADJ;
        end
      end
      S_UPD_ADJ:    state_nxt = stat.walk_at_src ? S_TOTALS : S_UPD_LINK;
      S_UPD_LINK:   state_nxt = S_UPD_CALC;
      S_UPD_CALC:   state_nxt = stat.cap_full ? S_UPD_WRITE : S_UPD_DIV;
      S_UPD_DIV:    if (!stat.div_busy) state_nxt = S_UPD_WRITE;
      S_UPD_WRITE:  state_nxt = S_UPD_ADJ;
      S_TOTALS:     state_nxt = S_EMIT_PATH;
      S_EMIT_PATH:  if (stat.out_free && stat.emit_last) state_nxt = S_IDLE;
      S_FINAL:      if (stat.out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.code  = code_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR:      cmd.op = OP_CLEAR_STEP;
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_CAPTURE;
      end
      S_STORE_AB:   cmd.op = OP_STORE_AB;
      S_STORE_BA:   cmd.op = OP_STORE_BA;
      S_ROUTE_INIT: if (!stat.ends_bad) cmd.op = OP_ROUTE_INIT;
      S_POP:        if (stat.queue_empty && !stat.dst_unreached) cmd.op = OP_WALK_INIT;
      S_POP_WAIT:   cmd.op = OP_POP_LATCH;
      S_SCAN:       cmd.op = stat.scan_done ? OP_NEXT_VISIT : OP_SCAN_READ;
      S_SCAN_ADJ:   if (stat.adj_absent) cmd.op = OP_SCAN_SKIP;
      S_SCAN_COST: begin
        if (stat.skip_link) cmd.op = OP_SCAN_SKIP;
        else if (!stat.queue_full) cmd.op = OP_RELAX;
      end
      S_PATH_WALK: begin
        if (stat.walk_at_src) cmd.op = OP_WALK_SRC;
        else if (!stat.walk_too_long) cmd.op = OP_WALK;
      end
      S_CHK_ADJ:    if (stat.walk_at_src) cmd.op = OP_WALK_RESTART;
      S_CHK_LINK:   cmd.op = OP_NONE;
      S_CHK_CMP:    if (!stat.over_cap) cmd.op = OP_WALK_STEP;
      S_UPD_ADJ:    cmd.op = OP_NONE;
      S_UPD_LINK:   cmd.op = OP_NONE;
      S_UPD_CALC:   cmd.op = OP_UPD_CALC;
      S_UPD_DIV:    cmd.op = OP_NONE;
      S_UPD_WRITE:  cmd.op = OP_UPD_WRITE;
      S_TOTALS:     cmd.op = OP_TOTALS;
      S_EMIT_PATH:  if (stat.out_free) cmd.op = OP_EMIT_PATH;
      S_FINAL:      if (stat.out_free) cmd.op = OP_EMIT_FINAL;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      code_r  <= ST_STORED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fap_dp.sv -----
// Datapath: link tables, adjacency and queue RAMs, distance labels, path walk and output register.
// Depends on fap_pkg, fap_ram, fap_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_admission_shortest_path_macros.svh"

module fap_dp import fap_pkg::*; #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [NCW-1:0]        cfg_wr_data,
  input  wire fap_cmd_t              cmd,
  output fap_stat_t                  stat,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  output logic      [2:0]            out_tuser,
  output logic                       out_tlast
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCW-1:0] QFULL     = QCW'(QUEUE_DEPTH);
  localparam logic [QAW:0]   QDEPTH_X  = (QAW + 1)'(QUEUE_DEPTH);
  localparam logic [QAW-1:0] QLAST     = QAW'(QUEUE_DEPTH - 1);

  logic [NCW-1:0]     node_count_r;
  logic [NCW-1:0]     n_act;
  logic [LW-1:0]      li_r;
  logic [NW-1:0]      src_r, dst_r;
  logic [AMT_W-1:0]   amt_r;
  logic [TAG_W-1:0]   tag_r;
  logic [ADJ_AW-1:0]  clr_idx_r;
  logic [QAW-1:0]     head_r;
  logic [QCW-1:0]     cnt_r;
  logic [NW-1:0]      now_r;
  logic [DIST_W-1:0]  dist_now_r;
  logic [NCW-1:0]     i_r;
  logic [DIST_W-1:0]  dist_r [NODES];
  logic [NODES-1:0]   dist_vld_r;
  logic [NW-1:0]      par_r [NODES];
  logic [NW-1:0]      walk_r;
  logic [LEN_W-1:0]   len_r;
  logic [NW-1:0]      rev_r [MAX_RES];
  logic [KW-1:0]      k_r;
  logic [LW-1:0]      ul_r;
  logic [AMT_W-1:0]   ucap_r, uld_r;
  logic               ufull_r;
  logic [TOTAL_W-1:0] total_r;
  logic [COUNT_W-1:0] count_r;
  logic               out_vld_r;
  fap_status_t        out_st_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [NW-1:0]      out_node_r;
  logic               out_last_r;
  logic [TOTAL_W-1:0] out_tot_r;
  logic [COUNT_W-1:0] out_cnt_r;

  logic               adj_we;
  logic [ADJ_AW-1:0]  adj_waddr, adj_raddr;
  logic [ADJ_W-1:0]   adj_wdata, adj_q;
  logic               link_we;
  logic [LW-1:0]      link_waddr, link_raddr;
  logic [LINK_WORD_W-1:0] link_wdata, link_q;
  logic [AMT_W-1:0]   l_cap, l_load;
  logic [COST_W-1:0]  l_cost;
  logic               q_we;
  logic [QAW-1:0]     q_waddr, q_tail;
  logic [QAW:0]       tail_sum;
  logic [NW-1:0]      q_wdata, q_q;
  logic [NW-1:0]      drd_idx;
  logic [DIST_W-1:0]  drd, dnew;
  logic [DIST_W:0]    dsum;
  logic               relax;
  logic [AMT_W:0]     ld_sum;
  logic [AMT_W-1:0]   ld_sat;
  logic               cap_full_now;
  logic               div_start, div_busy;
  logic [QUO_W-1:0]   div_q;
  logic [COST_W-1:0]  new_cost;
  logic [TOTAL_W:0]   tsum;
  logic               out_free;
  logic               emit_now;

  assign n_act = (node_count_r == '0) ? NCW'(1) :
                 (node_count_r > NCW'(NODES)) ? NCW'(NODES) : node_count_r;

  // adjacency store
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = clr_idx_r;
    adj_wdata = '0;
    case (cmd.op)
      OP_CLEAR_STEP: adj_we = 1'b1;
      OP_STORE_AB: begin
        adj_we    = 1'b1;
        adj_waddr = {src_r, dst_r};
        adj_wdata = ADJ_W'(li_r) + ADJ_W'(1);
      end
      OP_STORE_BA: begin
        adj_we    = 1'b1;
        adj_waddr = {dst_r, src_r};
        adj_wdata = ADJ_W'(li_r) + ADJ_W'(1);
      end
      default: adj_we = 1'b0;
    endcase
  end

  assign adj_raddr = (cmd.op == OP_SCAN_READ) ? {now_r, i_r[NW-1:0]}
                                              : {walk_r, par_r[walk_r]};

  fap_ram #(.WIDTH(ADJ_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_we),
    .wr_addr (adj_waddr),
    .wr_data (adj_wdata),
    .rd_addr (adj_raddr),
    .rd_data (adj_q)
  );

  // link table: capacity, load, cost
  assign link_raddr = LW'(adj_q - ADJ_W'(1));
  assign l_cap      = link_q[AMT_W-1:0];
  assign l_load     = link_q[2*AMT_W-1:AMT_W];
  assign l_cost     = link_q[LINK_WORD_W-1:2*AMT_W];
  assign new_cost   = ufull_r ? COST_UNUSABLE : {1'b0, div_q};

  always_comb begin
    link_we    = 1'b0;
    link_waddr = li_r;
    link_wdata = {{COST_W{1'b0}}, {AMT_W{1'b0}}, amt_r};
    case (cmd.op)
      OP_STORE_AB:  link_we = 1'b1;
      OP_UPD_WRITE: begin
        link_we    = 1'b1;
        link_waddr = ul_r;
        link_wdata = {new_cost, uld_r, ucap_r};
      end
      default: link_we = 1'b0;
    endcase
  end

  fap_ram #(.WIDTH(LINK_WORD_W), .DEPTH(LINKS)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (link_raddr),
    .rd_data (link_q)
  );

  // work queue
  assign tail_sum = {1'b0, head_r} + (QAW + 1)'(cnt_r);
  assign q_tail   = (tail_sum >= QDEPTH_X) ? QAW'(tail_sum - QDEPTH_X) : tail_sum[QAW-1:0];
  assign q_we     = (cmd.op == OP_ROUTE_INIT) || (cmd.op == OP_RELAX);
  assign q_waddr  = (cmd.op == OP_ROUTE_INIT) ? '0 : q_tail;
  assign q_wdata  = (cmd.op == OP_ROUTE_INIT) ? src_r : i_r[NW-1:0];

  fap_ram #(.WIDTH(NW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_addr (head_r),
    .rd_data (q_q)
  );

  // relaxation
  assign drd_idx = (cmd.op == OP_POP_LATCH) ? q_q : i_r[NW-1:0];
  assign drd     = dist_vld_r[drd_idx] ? dist_r[drd_idx] : DIST_INF;
  assign dsum    = {1'b0, dist_now_r} + (DIST_W + 1)'(l_cost[QUO_W-1:0]);
  assign dnew    = (dsum > {1'b0, DIST_MAX}) ? DIST_MAX : dsum[DIST_W-1:0];
  assign relax   = dnew < drd;

  // load update and cost division
  assign ld_sum       = {1'b0, l_load} + {1'b0, amt_r};
  assign ld_sat       = ld_sum[AMT_W] ? {AMT_W{1'b1}} : ld_sum[AMT_W-1:0];
  assign cap_full_now = !(l_cap > ld_sat);
  assign div_start    = (cmd.op == OP_UPD_CALC) && !cap_full_now;

  fap_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({ld_sat, {AMT_W{1'b0}}}),
    .divisor  (l_cap - ld_sat),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign tsum     = {1'b0, total_r} + (TOTAL_W + 1)'(amt_r);
  assign out_free = !out_vld_r || out_tready;
  assign emit_now = (cmd.op == OP_EMIT_PATH) || (cmd.op == OP_EMIT_FINAL);

  // status to controller
  always_comb begin
    stat.clr_done      = clr_idx_r == ADJ_AW'(ADJ_DEPTH - 1);
    stat.ends_bad      = (NCW'(src_r) >= n_act) || (NCW'(dst_r) >= n_act);
    stat.queue_empty   = cnt_r == '0;
    stat.dst_unreached = (dst_r != src_r) && !dist_vld_r[dst_r];
    stat.scan_done     = i_r == n_act;
    stat.adj_absent    = adj_q == '0;
    stat.skip_link     = l_cost[QUO_W] || !relax;
    stat.queue_full    = cnt_r == QFULL;
    stat.walk_at_src   = walk_r == src_r;
    stat.walk_too_long = (len_r >= LEN_W'(MAX_RES - 1)) || (len_r >= n_act);
    stat.over_cap      = ld_sum > {1'b0, l_cap};
    stat.cap_full      = cap_full_now;
    stat.div_busy      = div_busy;
    stat.out_free      = out_free;
    stat.emit_last     = k_r == '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCW'(NODES);
      clr_idx_r    <= '0;
      head_r       <= '0;
      cnt_r        <= '0;
      dist_vld_r   <= '0;
      total_r      <= '0;
      count_r      <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) node_count_r <= cfg_wr_data;
      out_vld_r <= emit_now || (out_vld_r && !out_tready);
      case (cmd.op)
        OP_CLEAR_STEP: clr_idx_r <= clr_idx_r + ADJ_AW'(1);
        OP_ROUTE_INIT: begin
          dist_vld_r <= {{(NODES-1){1'b0}}, 1'b1} << src_r;
          head_r     <= '0;
          cnt_r      <= QCW'(1);
        end
        OP_NEXT_VISIT: begin
          head_r <= (head_r == QLAST) ? '0 : head_r + QAW'(1);
          cnt_r  <= cnt_r - QCW'(1);
        end
        OP_RELAX: begin
          dist_vld_r[i_r[NW-1:0]] <= 1'b1;
          cnt_r                   <= cnt_r + QCW'(1);
        end
        OP_TOTALS: begin
          total_r <= tsum[TOTAL_W] ? {TOTAL_W{1'b1}} : tsum[TOTAL_W-1:0];
          if (count_r != {COUNT_W{1'b1}}) count_r <= count_r + COUNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        li_r  <= in_tdata[5:0];
        src_r <= in_tdata[10:6];
        dst_r <= in_tdata[15:11];
        amt_r <= in_tdata[31:16];
        tag_r <= in_tdata[47:32];
      end
      OP_ROUTE_INIT: dist_r[src_r] <= '0;
      OP_POP_LATCH: begin
        now_r      <= q_q;
        dist_now_r <= drd;
        i_r        <= '0;
      end
      OP_SCAN_SKIP: i_r <= i_r + NCW'(1);
      OP_RELAX: begin
        dist_r[i_r[NW-1:0]] <= dnew;
        par_r[i_r[NW-1:0]]  <= now_r;
        i_r                 <= i_r + NCW'(1);
      end
      OP_WALK_INIT: begin
        walk_r <= dst_r;
        len_r  <= '0;
      end
      OP_WALK: begin
        rev_r[len_r[KW-1:0]] <= walk_r;
        len_r                <= len_r + LEN_W'(1);
        walk_r               <= par_r[walk_r];
      end
      OP_WALK_SRC: begin
        rev_r[len_r[KW-1:0]] <= src_r;
        len_r                <= len_r + LEN_W'(1);
        walk_r               <= dst_r;
      end
      OP_WALK_STEP:    walk_r <= par_r[walk_r];
      OP_WALK_RESTART: walk_r <= dst_r;
      OP_UPD_CALC: begin
        ul_r    <= link_raddr;
        ucap_r  <= l_cap;
        uld_r   <= ld_sat;
        ufull_r <= cap_full_now;
      end
      OP_UPD_WRITE: walk_r <= par_r[walk_r];
      OP_TOTALS:    k_r <= KW'(len_r - LEN_W'(1));
      OP_EMIT_PATH: begin
        out_st_r   <= ST_ACCEPTED;
        out_tag_r  <= tag_r;
        out_node_r <= rev_r[k_r];
        out_last_r <= k_r == '0;
        out_tot_r  <= total_r;
        out_cnt_r  <= count_r;
        k_r        <= k_r - KW'(1);
      end
      OP_EMIT_FINAL: begin
        out_st_r   <= cmd.code;
        out_tag_r  <= tag_r;
        out_node_r <= '0;
        out_last_r <= 1'b1;
        out_tot_r  <= total_r;
        out_cnt_r  <= count_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_tot_r, out_node_r, out_tag_r};

  `FAP_ASSERT_IMPL(a_queue_count_range, 1'b1, cnt_r <= QFULL, "queue count beyond depth")
  `FAP_ASSERT_IMPL(a_push_not_full, cmd.op == OP_RELAX, cnt_r != QFULL, "push into full queue")
  `FAP_ASSERT_IMPL(a_write_after_div, cmd.op == OP_UPD_WRITE, !div_busy, "cost written mid-divide")
  `FAP_ASSERT_NEXT(a_emit_shows, emit_now, out_vld_r, "emitted transaction not presented")

endmodule

`default_nettype wire

// ----- hw/rtl/flow_admission_shortest_path.sv -----
// Channel  | ports          | payload (low bits first)
// in       | in_t*          | tuser: mode; tdata: link_index, endpoint_a, endpoint_b, amount, flow_id
// out      | out_t*         | tuser: status; tdata: flow_tag, path_node, accepted_total, accepted_count
// cfg      | cfg_wr_*       | node_count
// A link store writes both adjacency entries and the link word. A route pops each queue
// entry and scans its neighbours, walks the path back from the destination, checks each
// path link, updates each (one Q16.16 divide, one bit a cycle; none when the link fills)
// and sends the path nodes. After reset the adjacency RAM is cleared before the first transaction.
// A stalled output holds the block once the next result is ready; one result may wait
// while the next transaction is accepted.
// Top level: joins fap_ctrl and fap_dp; depends on fap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flow_admission_shortest_path import fap_pkg::*; #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // link_index, endpoint_a, endpoint_b, amount, flow_id
  input  wire logic                  in_tuser,   // mode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // flow_tag, path_node, accepted_total, accepted_count
  output logic      [2:0]            out_tuser,  // status
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [NCW-1:0]        cfg_wr_data
);

  fap_cmd_t  cmd;
  fap_stat_t stat;

  fap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fap_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for flow_admission_shortest_path: directed link/flow table, then random
// phases over several node counts, each result checked against an in-bench routing predictor.
// Depends on fap_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
  import fap_pkg::*;

  typedef struct {
    logic        mode;
    logic [5:0]  li;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [15:0] amt;
    logic [15:0] id;
    logic        chk;
    fap_status_t st;
  } flow_req_t;

  typedef struct {
    fap_status_t st;
    logic [15:0] tag;
    logic [4:0]  node;
    logic        last;
    logic [31:0] total;
    logic [15:0] count;
  } route_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // link_index, endpoint_a, endpoint_b, amount, flow_id
  logic in_tuser = 1'b0;                 // mode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // flow_tag, path_node, accepted_total, accepted_count
  logic [2:0] out_tuser;                 // status
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [NCW-1:0] cfg_wr_data = '0;

  // predictor state
  logic [ADJ_W-1:0]  m_adj [ADJ_DEPTH];
  logic [AMT_W-1:0]  m_cap [LINKS];
  logic [AMT_W-1:0]  m_load [LINKS];
  logic [COST_W-1:0] m_cost [LINKS];
  logic [5:0]        m_nodes;
  logic [31:0]       m_total;
  logic [15:0]       m_count;

  route_res_t pending_results[$];
  flow_req_t  dir_tab[$];
  int mismatches = 0;
  int n_items = 0, n_results = 0, n_accepted = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  flow_admission_shortest_path DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic void push_result(fap_status_t st, logic [15:0] tag, logic [4:0] node,
                                      logic last);
    route_res_t r;
    r.st = st; r.tag = tag; r.node = node; r.last = last;
    r.total = m_total; r.count = m_count;
    pending_results = {pending_results, r};
  endfunction

  // shortest-path search with admission check; fills path (source first) on acceptance
  function automatic fap_status_t route_flow(int src, int dst, logic [15:0] size,
                                             ref int path[$]);
    logic [DIST_W-1:0] dist_lbl [NODES];
    int par [NODES];
    int wq [1024];
    int rev[$];
    int n, head, cnt, now, i, l;
    logic [DIST_W:0] d;
    logic [COST_W-1:0] c;
    logic [ADJ_W-1:0] e;
    logic [16:0] ld;
    n = (m_nodes < 1) ? 1 : (m_nodes > NODES) ? NODES : m_nodes;
    if (src >= n || dst >= n) return ST_UNREACHABLE;
    for (i = 0; i < NODES; i++) begin
      dist_lbl[i] = DIST_INF;
      par[i] = 0;
    end
    dist_lbl[src] = '0;
    wq[0] = src;
    head = 0;
    cnt = 1;
    while (cnt > 0) begin
      now = wq[head];
      for (i = 0; i < n; i++) begin
        e = m_adj[now * NODES + i];
        if (e == 0) continue;
        c = m_cost[LW'(e - 1)];
        if (c[COST_W-1]) continue;
        d = dist_lbl[now] + c;
        if (d > DIST_MAX) d = DIST_MAX;
        if (d < dist_lbl[i]) begin
          if (cnt == 1024) return ST_QUEUE_OVERFLOW;
          dist_lbl[i] = d[DIST_W-1:0];
          par[i] = now;
          wq[(head + cnt) % 1024] = i;
          cnt++;
        end
      end
      head = (head + 1) % 1024;
      cnt--;
    end
    if (dst != src && dist_lbl[dst] == DIST_INF) return ST_UNREACHABLE;
    now = dst;
    while (now != src) begin
      if (rev.size() >= MAX_RES - 1 || rev.size() >= n) return ST_UNREACHABLE;
      rev = {rev, now};
      now = par[now];
    end
    rev = {rev, src};
    now = dst;
    while (now != src) begin
      l = LW'(m_adj[now * NODES + par[now]] - 1);
      if (17'(m_load[l]) + size > 17'(m_cap[l])) return ST_OVER_CAP;
      now = par[now];
    end
    path = {};
    for (i = rev.size() - 1; i >= 0; i--) path = {path, rev[i]};
    now = dst;
    while (now != src) begin
      l = LW'(m_adj[now * NODES + par[now]] - 1);
      ld = 17'(m_load[l]) + size;
      if (ld > 17'hFFFF) ld = 17'hFFFF;
      m_load[l] = ld[15:0];
      if (m_cap[l] > ld[15:0])
        m_cost[l] = COST_W'({16'(ld), 16'h0} / 32'(m_cap[l] - ld[15:0]));
      else
        m_cost[l] = COST_UNUSABLE;
      now = par[now];
    end
    m_total = (m_total > 32'hFFFF_FFFF - size) ? 32'hFFFF_FFFF : m_total + size;
    if (m_count < 16'hFFFF) m_count++;
    return ST_ACCEPTED;
  endfunction

  function automatic void predict_request(flow_req_t r);
    int path[$];
    fap_status_t st;
    if (!r.mode) begin
      m_cap[r.li] = r.amt;
      m_load[r.li] = '0;
      m_cost[r.li] = '0;
      m_adj[r.a * NODES + r.b] = ADJ_W'(r.li) + 1;
      m_adj[r.b * NODES + r.a] = ADJ_W'(r.li) + 1;
      push_result(ST_STORED, r.id, '0, 1'b1);
      return;
    end
    st = route_flow(r.a, r.b, r.amt, path);
    if (r.chk && st != r.st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row flow %0d: predicted status %0d, listed %0d", r.id, st, r.st);
    end
    if (st != ST_ACCEPTED) begin
      push_result(st, r.id, '0, 1'b1);
      return;
    end
    n_accepted++;
    foreach (path[k]) push_result(ST_ACCEPTED, r.id, path[k], k == path.size() - 1);
  endfunction

  task automatic send_request(flow_req_t r);
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {r.id, r.amt, r.b, r.a, r.li};
    do @(posedge clk); while (!in_tready);
    predict_request(r);
    n_items++;
  endtask

  task automatic sender_gap();
    int r, g;
    r = $urandom_range(0, 99);
    g = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(20, 100);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_nodes(logic [5:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_nodes = v;
  endtask

  function automatic void row(logic mode, logic [5:0] li, logic [4:0] a, logic [4:0] b,
                              logic [15:0] amt, logic [15:0] id, logic chk, fap_status_t st);
    flow_req_t r;
    r.mode = mode; r.li = li; r.a = a; r.b = b; r.amt = amt; r.id = id; r.chk = chk; r.st = st;
    dir_tab = {dir_tab, r};
  endfunction

  // receiver: random readiness, one long hold-off on request
  initial begin
    int r;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        out_tready <= (r < 60);
        if (r < 60) repeat ($urandom_range(1, 40)) @(posedge clk);
        else if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(20, 200)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    route_res_t x;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d tag %h", out_tuser, out_tdata[15:0]);
      end else begin
        x = pending_results.pop_front();
        if (out_tuser !== x.st || out_tdata[15:0] !== x.tag || out_tdata[20:16] !== x.node ||
            out_tlast !== x.last || out_tdata[52:21] !== x.total ||
            out_tdata[68:53] !== x.count || out_tdata[71:69] !== 3'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d tag %h node %0d last %0d tot %0d cnt %0d, got %0d %h %0d %0d %0d %0d",
                     x.st, x.tag, x.node, x.last, x.total, x.count, out_tuser,
                     out_tdata[15:0], out_tdata[20:16], out_tlast, out_tdata[52:21],
                     out_tdata[68:53]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    flow_req_t r;
    logic [5:0] phase_nodes [6] = '{6'd8, 6'd63, 6'd1, 6'd0, 6'd20, 6'd32};
    int neff, pick;
    for (int i = 0; i < ADJ_DEPTH; i++) m_adj[i] = '0;
    for (int i = 0; i < LINKS; i++) begin
      m_cap[i] = '0; m_load[i] = '0; m_cost[i] = '0;
    end
    m_nodes = 6'd32; m_total = '0; m_count = '0;

    row(0, 6'd0, 5'd0, 5'd1, 16'd100, 16'h0000, 1, ST_STORED);
    row(0, 6'd63, 5'd1, 5'd2, 16'hFFFF, 16'hFFFF, 1, ST_STORED);
    row(1, 6'd0, 5'd0, 5'd2, 16'd0, 16'd1, 0, ST_ACCEPTED);
    row(1, 6'd0, 5'd5, 5'd5, 16'd10, 16'd2, 1, ST_ACCEPTED);
    row(1, 6'd0, 5'd0, 5'd7, 16'd1, 16'd3, 1, ST_UNREACHABLE);
    row(1, 6'd0, 5'd0, 5'd2, 16'hFFFF, 16'd4, 1, ST_OVER_CAP);
    row(1, 6'd0, 5'd0, 5'd1, 16'd100, 16'd5, 0, ST_ACCEPTED);
    row(1, 6'd0, 5'd0, 5'd2, 16'd1, 16'd6, 1, ST_UNREACHABLE);
    row(0, 6'd0, 5'd0, 5'd1, 16'd0, 16'd7, 1, ST_STORED);
    row(1, 6'd0, 5'd0, 5'd1, 16'd0, 16'd8, 0, ST_ACCEPTED);
    row(0, 6'd5, 5'd31, 5'd30, 16'd200, 16'd9, 1, ST_STORED);
    row(0, 6'd5, 5'd2, 5'd31, 16'd300, 16'd10, 1, ST_STORED);
    row(1, 6'd0, 5'd30, 5'd2, 16'd7, 16'd11, 0, ST_ACCEPTED);
    row(1, 6'd63, 5'd31, 5'd1, 16'd9, 16'hFFFF, 0, ST_ACCEPTED);
    row(1, 6'd0, 5'd2, 5'd0, 16'd1, 16'hA5A5, 0, ST_ACCEPTED);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i]) begin
      send_request(dir_tab[i]);
      sender_gap();
    end

    foreach (phase_nodes[p]) begin
      drain();
      write_nodes(phase_nodes[p]);
      neff = (phase_nodes[p] < 1) ? 1 : (phase_nodes[p] > NODES) ? NODES : phase_nodes[p];
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < 14; k++) begin
        pick = $urandom_range(0, 99);
        r.chk = 1'b0; r.st = ST_STORED;
        r.li = $urandom_range(0, 63);
        r.id = $urandom;
        r.mode = (pick >= 35);
        if (pick < 90) begin
          r.a = $urandom_range(0, (neff < 31) ? neff : 31);
          r.b = $urandom_range(0, (neff < 31) ? neff : 31);
        end else begin
          r.a = $urandom_range(0, 31);
          r.b = $urandom_range(0, 31);
        end
        if (!r.mode) r.amt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom;
        else r.amt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500);
        send_request(r);
        sender_gap();
      end
    end
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d requests, %0d results, %0d flows admitted, node counts 0 to 63",
             n_items, n_results, n_accepted);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
